// ===== design/urds_pkg.sv =====
`timescale 1ns / 1ps
// Package: request/result beat types, datagram constants, CRC helper and control types.
package urds_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // configuration register indexes
    localparam logic REG_NODE_ADDRESS = 1'b0;

    // byte positions inside a datagram
    localparam int unsigned POS_W = 3;
    localparam logic [POS_W-1:0] POS_SYNC      = 3'd0;
    localparam logic [POS_W-1:0] POS_NODE      = 3'd1;
    localparam logic [POS_W-1:0] POS_ADDR      = 3'd2;
    localparam logic [POS_W-1:0] POS_VAL3      = 3'd3;  // also the read CRC slot
    localparam logic [POS_W-1:0] POS_VAL2      = 3'd4;
    localparam logic [POS_W-1:0] POS_VAL1      = 3'd5;
    localparam logic [POS_W-1:0] POS_VAL0      = 3'd6;
    localparam logic [POS_W-1:0] POS_WRITE_CRC = 3'd7;

    typedef struct packed {
        logic               command;
        logic [6:0]         reg_address;
        logic signed [31:0] write_value;
    } request_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [9:0] line_char;
        logic       last_byte;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

    // CRC-8 update over one byte, data fed LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] d;
        logic       fb;
        crc = crc_in;
        d   = data;
        for (int j = 0; j < 8; j++)
        begin
            fb  = crc[7] ^ d[0];
            crc = {crc[6:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return crc;
    endfunction

endpackage

// ===== design/urds_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one datagram per accepted request.
module urds_ctrl
    import urds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                busy     = 1'b1;
                cmd.emit = 1'b1;
                if (status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/urds_dp.sv =====
`timescale 1ns / 1ps
// Datapath: request latch, byte position counter, running CRC and result registers.
module urds_dp
    import urds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  request_t   request,
    input  logic [7:0] node_address,
    output result_t    result,
    output logic       strobe
);

    request_t         req_reg;
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       crc_reg;
    result_t          result_reg;
    logic             strobe_reg;

    logic [7:0]       cur_byte;
    logic             is_crc;
    logic [31:0]      value;

    assign value = req_reg.write_value;

    always_comb
    begin
        is_crc   = 1'b0;
        cur_byte = SYNC_BYTE;
        unique case (pos_reg)
            POS_SYNC: cur_byte = SYNC_BYTE;
            POS_NODE: cur_byte = node_address;
            POS_ADDR: cur_byte = {req_reg.command == CMD_WRITE, req_reg.reg_address};
            POS_VAL3:
            begin
                if (req_reg.command == CMD_READ)
                begin
                    is_crc   = 1'b1;
                    cur_byte = crc_reg;
                end
                else
                begin
                    cur_byte = value[31:24];
                end
            end
            POS_VAL2: cur_byte = value[23:16];
            POS_VAL1: cur_byte = value[15:8];
            POS_VAL0: cur_byte = value[7:0];
            POS_WRITE_CRC:
            begin
                is_crc   = 1'b1;
                cur_byte = crc_reg;
            end
            default:
            begin
                cur_byte = SYNC_BYTE;
            end
        endcase
    end

    assign status.last = is_crc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            pos_reg    <= POS_SYNC;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.load)
            begin
                pos_reg <= POS_SYNC;
            end
            else if (cmd.emit)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
            crc_reg <= CRC_INIT;
        end
        else if (cmd.emit)
        begin
            crc_reg <= crc8_byte(crc_reg, cur_byte);
        end
        if (cmd.emit)
        begin
            result_reg.frame_byte <= cur_byte;
            result_reg.line_char  <= {1'b1, cur_byte, 1'b0};
            result_reg.last_byte  <= is_crc;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

// ===== design/uart_register_datagram_sender_core.sv =====
`timescale 1ns / 1ps
// Top level: UART register datagram sender with its configuration port.
//
// Usage:
//   A request beat (command, reg_address, write_value) is taken on a rising
//   edge with start high and busy low. The block then sends the datagram one
//   byte per cycle on result, each byte marked by a one-cycle strobe: eight
//   bytes for a register write, four for a read request. last_byte marks the
//   trailing CRC-8 byte. result carries the byte and its 10-bit UART character.
//   The first byte reaches result through the controller state register and
//   then the result register after the accept; bytes follow one per cycle.
//   A new request is taken only once the last byte of the current datagram
//   has been sequenced; busy is high while the byte sequencer runs.
//   The receiver cannot stall: every strobed byte must be taken at once.
//   node_address is written over the APB port at byte address 0 and read
//   back there; write it only while busy is low and no byte is pending.
//   Reset clears the sequencer, the strobe and node_address (to 0).
module uart_register_datagram_sender_core
    import urds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  request_t    request,
    output result_t     result,
    output logic        strobe,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [7:0] node_address_reg;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_NODE_ADDRESS) && (paddr[1:0] == 2'b00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= 8'h00;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            node_address_reg <= pwdata[7:0];
        end
    end

    assign prdata = reg_hit ? {24'h000000, node_address_reg} : 32'h00000000;

    urds_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    urds_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .request      (request),
        .node_address (node_address_reg),
        .result       (result),
        .strobe       (strobe)
    );

endmodule

// ===== bench/urds_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts the datagram bytes of each request and compares every strobed beat.
module urds_checker
    import urds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  request_t    request,
    input  result_t     result,
    input  logic        strobe,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          write_requests,
    output int          read_requests,
    output int          bytes_checked
);

    result_t    expected_bytes[$];
    logic [7:0] node_copy;
    int         errors;
    int         n_writes;
    int         n_reads;
    int         n_bytes;

    // byte i of the frame sits at [8*i +: 8]; bits go into the CRC LSB first
    function automatic logic [7:0] datagram_crc8(input logic [63:0] frame, input int count);
        logic [7:0] crc;
        logic       fb;
        crc = CRC_INIT;
        for (int i = 0; i < 8 * count; i++)
        begin
            fb  = crc[7] ^ frame[i];
            crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    task automatic queue_datagram(input request_t req);
        logic [63:0] frame;
        logic [31:0] value;
        int          count;
        result_t     beat;
        value = req.write_value;
        frame = '0;
        frame[7:0]  = SYNC_BYTE;
        frame[15:8] = node_copy;
        if (req.command == CMD_READ)
        begin
            frame[23:16] = {1'b0, req.reg_address};
            frame[31:24] = datagram_crc8(frame, 3);
            count = 4;
        end
        else
        begin
            frame[23:16] = {1'b1, req.reg_address};
            frame[31:24] = value[31:24];
            frame[39:32] = value[23:16];
            frame[47:40] = value[15:8];
            frame[55:48] = value[7:0];
            frame[63:56] = datagram_crc8(frame, 7);
            count = 8;
        end
        for (int k = 0; k < count; k++)
        begin
            beat.frame_byte = frame[8*k +: 8];
            beat.line_char  = {1'b1, frame[8*k +: 8], 1'b0};
            beat.last_byte  = (k == count - 1);
            expected_bytes.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            node_copy = 8'h00;
            expected_bytes.delete();
            errors   = 0;
            n_writes = 0;
            n_reads  = 0;
            n_bytes  = 0;
        end
        else
        begin
            // result beats belong to earlier requests, so pop before pushing
            if (strobe)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat: byte %02h char %03h last %0b",
                             $time, result.frame_byte, result.line_char, result.last_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    n_bytes++;
                    if (result.frame_byte !== want.frame_byte ||
                        result.line_char !== want.line_char ||
                        result.last_byte !== want.last_byte)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected byte %02h char %03h last %0b",
                                 $time, want.frame_byte, want.line_char, want.last_byte);
                        $display("%0t:           actual byte %02h char %03h last %0b",
                                 $time, result.frame_byte, result.line_char,
                                 result.last_byte);
                    end
                end
            end

            if (start && !busy)
            begin
                queue_datagram(request);
                if (request.command == CMD_READ)
                    n_reads++;
                else
                    n_writes++;
            end

            if (psel && penable && pready && (paddr >> 2) == 3'(REG_NODE_ADDRESS))
            begin
                if (pwrite)
                    node_copy = pwdata[7:0];
                else if (prdata !== {24'h0, node_copy})
                begin
                    errors++;
                    $display("%0t: register read mismatch: expected %08h actual %08h",
                             $time, {24'h0, node_copy}, prdata);
                end
            end
        end
        fail_count     <= errors;
        pending        <= expected_bytes.size();
        write_requests <= n_writes;
        read_requests  <= n_reads;
        bytes_checked  <= n_bytes;
    end

endmodule

// ===== bench/uart_register_datagram_sender_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives requests and register writes, runs the checker, gives the verdict.
module uart_register_datagram_sender_core_tb;
    import urds_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    result_t     result;
    logic        strobe;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int write_requests;
    int read_requests;
    int bytes_checked;
    int cycles = 0;
    int node_settings;

    uart_register_datagram_sender_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .result  (result),
        .strobe  (strobe),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    urds_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .result         (result),
        .strobe         (strobe),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .write_requests (write_requests),
        .read_requests  (read_requests),
        .bytes_checked  (bytes_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d bytes still expected", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // one request beat; gap cycles of idle start before it, start left high afterwards
    task automatic send_request(input logic cmd, input logic [6:0] addr,
                                input logic [31:0] value, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= '{command: cmd, reg_address: addr, write_value: value};
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_random(input int gap);
        logic [31:0] value;
        logic [31:0] corners [4];
        corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        value = ($urandom_range(0, 9) == 0) ? corners[$urandom_range(0, 3)] : $urandom;
        send_request($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                     7'($urandom_range(0, 127)), value, gap);
    endtask

    // block must be idle before the port is touched
    task automatic drain;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_node(input logic [7:0] node);
        drain();
        apb_access(1'b1, 3'(REG_NODE_ADDRESS) << 2, {24'hFFFFFF, node});
        apb_access(1'b0, 3'(REG_NODE_ADDRESS) << 2, 32'h0);
        node_settings++;
    endtask

    initial
    begin
        logic [7:0] phase_nodes [5];
        node_settings = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value read back, then datagrams with node 0
        apb_access(1'b0, 3'(REG_NODE_ADDRESS) << 2, 32'h0);
        send_request(CMD_WRITE, 7'h00, 32'h0000_0000, 0);
        send_request(CMD_WRITE, 7'h7F, 32'hFFFF_FFFF, 0);
        send_request(CMD_READ,  7'h00, 32'h0000_0000, 0);
        send_request(CMD_READ,  7'h7F, 32'h0000_0000, 1);
        send_request(CMD_WRITE, 7'h55, 32'h8000_0000, 2);
        send_request(CMD_WRITE, 7'h2A, 32'h7FFF_FFFF, 0);
        // read requests ignore the value and send only four bytes
        send_request(CMD_READ,  7'h6C, 32'hDEAD_BEEF, 0);
        send_request(CMD_READ,  7'h01, 32'hFFFF_FFFF, 3);

        // write to an out-of-range register index must leave the node alone
        drain();
        apb_access(1'b1, 3'd4, 32'h0000_003C);
        apb_access(1'b0, 3'(REG_NODE_ADDRESS) << 2, 32'h0);
        send_request(CMD_WRITE, 7'h10, 32'h0123_4567, 0);
        send_request(CMD_READ,  7'h10, 32'h0000_0000, 0);

        set_node(8'hFF);
        send_request(CMD_WRITE, 7'h7F, 32'hFFFF_FFFF, 0);
        send_request(CMD_WRITE, 7'h00, 32'h0000_0000, 0);
        send_request(CMD_READ,  7'h7F, 32'h0000_0000, 0);
        send_request(CMD_READ,  7'h00, 32'hA5A5_A5A5, 0);
        send_request(CMD_WRITE, 7'h3C, 32'hFEDC_BA98, 5);
        send_request(CMD_WRITE, 7'h41, 32'h8000_0001, 8);

        phase_nodes[0] = 8'h00;
        phase_nodes[1] = 8'hFF;
        phase_nodes[2] = 8'($urandom);
        phase_nodes[3] = 8'hA5;
        phase_nodes[4] = 8'($urandom);
        for (int p = 0; p < 5; p++)
        begin
            set_node(phase_nodes[p]);
            // first stretch of every phase runs back to back
            for (int k = 0; k < 50; k++)
                send_random((k < 12) ? 0 : $urandom_range(0, 8));
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Covered %0d write and %0d read datagrams, %0d bytes checked,",
                 write_requests, read_requests, bytes_checked);
        $display("over %0d node address settings plus the reset value.", node_settings);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/urds_pkg.sv
design/urds_ctrl.sv
design/urds_dp.sv
design/uart_register_datagram_sender_core.sv
bench/urds_checker.sv
bench/uart_register_datagram_sender_core_tb.sv
